[hdl/modulo_bucket_hash_table_core_defines.svh]
// assertion macros for the modulo bucket hash table
// used by modulo_bucket_hash_table_core, expects clk and rst_n in scope
`ifndef MODULO_BUCKET_HASH_TABLE_CORE_DEFINES_SVH
`define MODULO_BUCKET_HASH_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define MBHT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbht assertion failed");

// next-cycle implication
`define MBHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbht assertion failed");

`endif

[hdl/mbht_pkg.sv]
`timescale 1ns / 1ps
// types and codes for the modulo bucket hash table
// no dependencies
package mbht_pkg;

  localparam int KEY_W  = 31;
  localparam int SLOT_W = 32;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] value;
    logic             found;
    logic             bucket_full;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_MOD,
    ST_EXEC
  } state_t;

endpackage

[hdl/modulo_bucket_hash_table_core.sv]
`timescale 1ns / 1ps
// hash table with bounded buckets, one row of slots per bucket
// depends on mbht_pkg and modulo_bucket_hash_table_core_defines.svh
`include "modulo_bucket_hash_table_core_defines.svh"

// A request is taken only while idle, and in_stall stays high until its
// result is registered: the word is taken, the key is multiplied by a
// reciprocal of BUCKETS, the remainder picks the bucket row and that row is
// read, then all slots of the row are compared and a changed row is written
// back with the result registered, held while the result side stalls. The
// steps follow the read-modify-write of one bucket row through the single-port
// row store. After reset a clearing pass writes every row empty, in_stall high.
module modulo_bucket_hash_table_core #(
  parameter int BUCKETS          = 100,
  parameter int SLOTS_PER_BUCKET = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mbht_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mbht_pkg::out_word_t out_data
);
  import mbht_pkg::*;

  localparam int ROW_AW = $clog2(BUCKETS);
  localparam int ROW_W  = SLOTS_PER_BUCKET * SLOT_W;
  localparam int PROD_W = 2 * KEY_W;
  localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / BUCKETS);
  localparam logic [SLOT_W-1:0] BUCKETS_W = SLOT_W'(BUCKETS);
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(BUCKETS - 1);
  localparam logic [SLOTS_PER_BUCKET-1:0] SLOT_ONE = SLOTS_PER_BUCKET'(1);

  state_t state_r, state_nxt;

  logic [1:0]        action_r;
  logic [KEY_W-1:0]  key_r;
  logic [PROD_W-1:0] prod_r;
  logic [ROW_AW-1:0] clr_row_r;
  logic [ROW_W-1:0]  rd_row_r;
  logic              out_valid_r;
  out_word_t         out_data_r, out_data_nxt;

  logic [ROW_W-1:0]  mem [BUCKETS];
  logic              mem_we;
  logic [ROW_AW-1:0] mem_wa;
  logic [ROW_W-1:0]  mem_wd;
  logic              mem_re;

  logic [KEY_W-1:0]  quot;
  logic [SLOT_W-1:0] diff;
  logic [SLOT_W-1:0] rem;
  logic [ROW_AW-1:0] row_idx_r;

  logic [SLOTS_PER_BUCKET-1:0] vld, hit, free, free_oh, hit_oh;
  logic [ROW_W-1:0]            new_row;
  logic                        row_write;
  logic                        exec_go;

  // remainder of key by BUCKETS, estimate is low by at most one
  always_comb begin
    quot = prod_r[PROD_W-1:KEY_W];
    diff = {1'b0, key_r} - (SLOT_W'(quot) * BUCKETS_W);
    rem  = (diff >= BUCKETS_W) ? (diff - BUCKETS_W) : diff;
  end

  // slot compare and row update
  always_comb begin
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      vld[s] = rd_row_r[s*SLOT_W + KEY_W];
      hit[s] = vld[s] && (rd_row_r[s*SLOT_W +: KEY_W] == key_r);
    end
    free    = ~vld;
    free_oh = free & (~free + SLOT_ONE);
    hit_oh  = hit & (~hit + SLOT_ONE);
    new_row = rd_row_r;
    out_data_nxt = '0;
    row_write = 1'b0;
    case (action_r)
      ACT_INSERT: begin
        for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
          if (free_oh[s]) begin
            new_row[s*SLOT_W +: SLOT_W] = {1'b1, key_r};
          end
        end
        out_data_nxt.found       = |free;
        out_data_nxt.bucket_full = ~(|free);
        row_write = |free;
      end
      ACT_REMOVE: begin
        for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
          if (hit_oh[s]) begin
            new_row[s*SLOT_W +: SLOT_W] = '0;
          end
        end
        out_data_nxt.value = (|vld) ? key_r : '0;
        out_data_nxt.found = |hit;
        row_write = |hit;
      end
      ACT_LOOKUP: begin
        out_data_nxt.value = (|hit) ? key_r : '0;
        out_data_nxt.found = |hit;
      end
      default: begin
        out_data_nxt = '0;
      end
    endcase
  end

  assign exec_go = !(out_valid_r && out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_row_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_MOD;
      ST_MOD:  state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (exec_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = 1'b1;
    mem_we   = 1'b0;
    mem_wa   = clr_row_r;
    mem_wd   = '0;
    mem_re   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_MOD: begin
        mem_re = 1'b1;
      end
      ST_EXEC: begin
        mem_we = exec_go && row_write;
        mem_wa = row_idx_r;
        mem_wd = new_row;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // row store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_row_r <= mem[rem[ROW_AW-1:0]];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      action_r <= in_data.action;
      key_r    <= in_data.key;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(key_r) * PROD_W'(RECIP);
    end
    if (state_r == ST_MOD) begin
      row_idx_r <= rem[ROW_AW-1:0];
    end
    if (state_r == ST_EXEC && exec_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_row_r <= clr_row_r + ROW_AW'(1);
      end
      if (state_r == ST_EXEC && exec_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MBHT_ASSERT_NEXT(a_accept_to_mul, in_valid && !in_stall, state_r == ST_MUL)
  `MBHT_ASSERT_NOW(a_rem_in_range, state_r == ST_MOD, rem < BUCKETS_W)
  `MBHT_ASSERT_NOW(a_we_phase, mem_we, state_r == ST_CLEAR || state_r == ST_EXEC)
  `MBHT_ASSERT_NOW(a_rose_after_exec, $rose(out_valid_r), $past(state_r == ST_EXEC))
  `MBHT_ASSERT_NOW(a_flags_excl, out_valid_r, !(out_data_r.found && out_data_r.bucket_full))

endmodule
